### hdl/vlr_pkg.sv
// Package for the 3D voxel line rasterizer.
// Shared types and fixed constants; no dependencies.
package vlr_pkg;

    // Fixed field widths
    localparam int GRID_W     = 7;
    localparam int SITE_W     = 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GRID_X    = 2'd0,
        CFG_GRID_Y    = 2'd1,
        CFG_GRID_Z    = 2'd2,
        CFG_SITE_BASE = 2'd3
    } cfg_idx_t;

    // Walk axis codes
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // Controller to walker commands
    typedef struct packed {
        logic load;   // capture endpoints, set up deltas
        logic emit;   // push current point, then step unless at the end
    } walk_cmd_t;

    // Walker to controller status
    typedef struct packed {
        logic last;   // current point is the end point
    } walk_sts_t;

endpackage

### hdl/voxel_line_rasterizer_3d.sv
// Top level of the 3D voxel line rasterizer.
// Depends on vlr_pkg, vlr_ctrl, vlr_walk and vlr_index.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one endpoint pair per item.
//   Output channel (out_valid/out_ready) gives one item per visited voxel,
//   start point first, with last set on the end point. A line whose largest
//   absolute delta is D gives D+1 items.
//   Config port: cfg_we/cfg_addr/cfg_wdata writes grid sizes and site base;
//   write only while no line is in flight.
// Timing:
//   The walker emits one point per cycle while the index pipeline can take
//   it, so a line holds the input side through a setup step, then D+1 steps;
//   in_ready is high only while the walker is idle. Results pass through the
//   two-stage index pipeline (multiply, then sum).
//   A new line is accepted while the previous line's last points still drain.
// Reset:
//   Grid sizes return to 64, site base to 0, all valid flags clear.
// Stall:
//   When out_ready is low the pipeline fills and the walker pauses; nothing
//   is dropped and results stay in order.
module voxel_line_rasterizer_3d #(
    parameter int COORD_BITS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vlr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vlr_pkg::SITE_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [COORD_BITS-1:0]          start_x,
    input  logic [COORD_BITS-1:0]          start_y,
    input  logic [COORD_BITS-1:0]          start_z,
    input  logic [COORD_BITS-1:0]          end_x,
    input  logic [COORD_BITS-1:0]          end_y,
    input  logic [COORD_BITS-1:0]          end_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [COORD_BITS-1:0]          voxel_x,
    output logic [COORD_BITS-1:0]          voxel_y,
    output logic [COORD_BITS-1:0]          voxel_z,
    output logic                           inside_grid,
    output logic [vlr_pkg::SITE_W-1:0]     site_index,
    output logic                           last
);
    import vlr_pkg::*;

    walk_cmd_t             cmd;
    walk_sts_t             sts;
    logic                  push_ready;
    logic [COORD_BITS-1:0] pt_x, pt_y, pt_z;

    // Sequencer
    vlr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .emit_ready (push_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Line walker
    vlr_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .clk     (clk),
        .start_x (start_x),
        .start_y (start_y),
        .start_z (start_z),
        .end_x   (end_x),
        .end_y   (end_y),
        .end_z   (end_z),
        .cmd     (cmd),
        .sts     (sts),
        .pt_x    (pt_x),
        .pt_y    (pt_y),
        .pt_z    (pt_z)
    );

    // Site index pipeline and output register
    vlr_index #(
        .COORD_BITS (COORD_BITS)
    ) u_index (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .push        (cmd.emit),
        .push_last   (sts.last),
        .pt_x        (pt_x),
        .pt_y        (pt_y),
        .pt_z        (pt_z),
        .push_ready  (push_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .voxel_x     (voxel_x),
        .voxel_y     (voxel_y),
        .voxel_z     (voxel_z),
        .inside_grid (inside_grid),
        .site_index  (site_index),
        .last        (last)
    );

endmodule

### hdl/vlr_ctrl.sv
// Controller for the voxel line rasterizer: idle/walk state machine.
// Depends on vlr_pkg.
module vlr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               emit_ready,
    input  vlr_pkg::walk_sts_t sts,
    output vlr_pkg::walk_cmd_t cmd
);
    import vlr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (emit_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

endmodule

### hdl/vlr_walk.sv
// Walker datapath: endpoint setup and one Bresenham step per emitted point but the last.
// Depends on vlr_pkg.
module vlr_walk #(
    parameter int COORD_BITS = 6
) (
    input  logic                  clk,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] start_z,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COORD_BITS-1:0] end_z,
    input  vlr_pkg::walk_cmd_t    cmd,
    output vlr_pkg::walk_sts_t    sts,
    output logic [COORD_BITS-1:0] pt_x,
    output logic [COORD_BITS-1:0] pt_y,
    output logic [COORD_BITS-1:0] pt_z
);
    import vlr_pkg::*;

    localparam int CB = COORD_BITS;

    logic [2:0][CB-1:0] pos_reg, pos_next;
    logic [2:0][CB-1:0] err_reg, err_next;
    logic [2:0][CB-1:0] abs_reg, abs_next;
    logic [2:0]         sign_reg, sign_next;
    axis_t              major_reg, major_next;
    logic [CB-1:0]      dmaj_reg, dmaj_next;
    logic [CB-1:0]      steps_reg, steps_next;

    logic [2:0][CB-1:0] s_pt;
    logic [2:0][CB-1:0] e_pt;
    logic [2:0][CB-1:0] ld_abs;
    logic [2:0]         ld_sign;
    axis_t              ld_major;
    logic [2:0][CB:0]   acc_sum;
    logic               do_step;

    assign s_pt = {start_z, start_y, start_x};
    assign e_pt = {end_z, end_y, end_x};

    // Setup: absolute deltas, directions and major axis (ties to lower axis)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ld_sign[i] = e_pt[i] < s_pt[i];
            ld_abs[i]  = ld_sign[i] ? (s_pt[i] - e_pt[i]) : (e_pt[i] - s_pt[i]);
        end
        ld_major = (ld_abs[1] > ld_abs[0]) ? AXIS_Y : AXIS_X;
        if (ld_abs[2] > ld_abs[ld_major])
        begin
            ld_major = AXIS_Z;
        end
    end

    assign do_step = cmd.emit && (steps_reg != '0);

    // Load or step
    always_comb
    begin
        pos_next   = pos_reg;
        err_next   = err_reg;
        abs_next   = abs_reg;
        sign_next  = sign_reg;
        major_next = major_reg;
        dmaj_next  = dmaj_reg;
        steps_next = steps_reg;
        for (int i = 0; i < 3; i++)
        begin
            acc_sum[i] = {1'b0, err_reg[i]} + {1'b0, abs_reg[i]};
        end
        priority if (cmd.load)
        begin
            pos_next   = s_pt;
            err_next   = '0;
            abs_next   = ld_abs;
            sign_next  = ld_sign;
            major_next = ld_major;
            dmaj_next  = ld_abs[ld_major];
            steps_next = ld_abs[ld_major];
        end
        else if (do_step)
        begin
            steps_next = steps_reg - CB'(1);
            for (int i = 0; i < 3; i++)
            begin
                if (major_reg == axis_t'(2'(i)))
                begin
                    pos_next[i] = pos_reg[i] + (sign_reg[i] ? '1 : CB'(1));
                end
                else if (acc_sum[i] >= {1'b0, dmaj_reg})
                begin
                    err_next[i] = CB'(acc_sum[i] - {1'b0, dmaj_reg});
                    pos_next[i] = pos_reg[i] + (sign_reg[i] ? '1 : CB'(1));
                end
                else
                begin
                    err_next[i] = acc_sum[i][CB-1:0];
                end
            end
        end
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        err_reg   <= err_next;
        abs_reg   <= abs_next;
        sign_reg  <= sign_next;
        major_reg <= major_next;
        dmaj_reg  <= dmaj_next;
        steps_reg <= steps_next;
    end

    assign sts.last = (steps_reg == '0);
    assign pt_x     = pos_reg[0];
    assign pt_y     = pos_reg[1];
    assign pt_z     = pos_reg[2];

endmodule

### hdl/vlr_index.sv
// Index pipeline: grid registers, in-grid test, linear site index, output register.
// Depends on vlr_pkg.
module vlr_index #(
    parameter int COORD_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vlr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [vlr_pkg::SITE_W-1:0]        cfg_wdata,
    input  logic                              push,
    input  logic                              push_last,
    input  logic [COORD_BITS-1:0]             pt_x,
    input  logic [COORD_BITS-1:0]             pt_y,
    input  logic [COORD_BITS-1:0]             pt_z,
    output logic                              push_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [COORD_BITS-1:0]             voxel_x,
    output logic [COORD_BITS-1:0]             voxel_y,
    output logic [COORD_BITS-1:0]             voxel_z,
    output logic                              inside_grid,
    output logic [vlr_pkg::SITE_W-1:0]        site_index,
    output logic                              last
);
    import vlr_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int CMP_W = CB + GRID_W;
    localparam int PY_W  = GRID_W + CB;
    localparam int XY_W  = 2 * GRID_W;
    localparam int PZ_W  = XY_W + CB;

    logic [GRID_W-1:0] gx_reg, gy_reg, gz_reg;
    logic [SITE_W-1:0] base_reg;
    logic [XY_W-1:0]   xy_reg;

    logic              s1_valid_reg;
    logic [CB-1:0]     s1_x_reg, s1_y_reg, s1_z_reg;
    logic              s1_in_reg, s1_last_reg;
    logic [SITE_W-1:0] s1_bx_reg;
    logic [PY_W-1:0]   s1_py_reg;
    logic [PZ_W-1:0]   s1_pz_reg;

    logic              out_valid_reg;
    logic [CB-1:0]     out_x_reg, out_y_reg, out_z_reg;
    logic              out_in_reg, out_last_reg;
    logic [SITE_W-1:0] out_idx_reg;

    logic              adv;
    logic              pt_in;
    logic [SITE_W-1:0] idx_sum;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg   <= GRID_RESET;
            gy_reg   <= GRID_RESET;
            gz_reg   <= GRID_RESET;
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_GRID_X:    gx_reg   <= cfg_wdata[GRID_W-1:0];
                CFG_GRID_Y:    gy_reg   <= cfg_wdata[GRID_W-1:0];
                CFG_GRID_Z:    gz_reg   <= cfg_wdata[GRID_W-1:0];
                CFG_SITE_BASE: base_reg <= cfg_wdata;
            endcase
        end
    end

    // Plane size X*Y, registered; settles before the first point of a line
    always_ff @(posedge clk)
    begin
        xy_reg <= XY_W'(gx_reg) * XY_W'(gy_reg);
    end

    // Stall control: output register frees when empty or taken
    assign adv        = !out_valid_reg || out_ready;
    assign push_ready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign pt_in = (CMP_W'(pt_x) < CMP_W'(gx_reg)) && (CMP_W'(pt_y) < CMP_W'(gy_reg))
                && (CMP_W'(pt_z) < CMP_W'(gz_reg));

    // Stage 1: in-grid test and partial products
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            s1_x_reg    <= pt_x;
            s1_y_reg    <= pt_y;
            s1_z_reg    <= pt_z;
            s1_in_reg   <= pt_in;
            s1_last_reg <= push_last;
            s1_bx_reg   <= base_reg + SITE_W'(pt_x);
            s1_py_reg   <= PY_W'(gx_reg) * PY_W'(pt_y);
            s1_pz_reg   <= PZ_W'(xy_reg) * PZ_W'(pt_z);
        end
    end

    // Stage 2: final sum, zero outside the grid
    assign idx_sum = s1_bx_reg + SITE_W'(s1_py_reg) + SITE_W'(s1_pz_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg    <= s1_x_reg;
            out_y_reg    <= s1_y_reg;
            out_z_reg    <= s1_z_reg;
            out_in_reg   <= s1_in_reg;
            out_last_reg <= s1_last_reg;
            out_idx_reg  <= s1_in_reg ? idx_sum : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign voxel_x     = out_x_reg;
    assign voxel_y     = out_y_reg;
    assign voxel_z     = out_z_reg;
    assign inside_grid = out_in_reg;
    assign site_index  = out_idx_reg;
    assign last        = out_last_reg;

endmodule

### hdl/vlr_checker.sv
// Port-level checker for the voxel line rasterizer, with its bind.
// Depends on vlr_pkg and voxel_line_rasterizer_3d.
module vlr_checker #(
    parameter int COORD_BITS = 6
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [COORD_BITS-1:0]      voxel_x,
    input logic                       inside_grid,
    input logic [vlr_pkg::SITE_W-1:0] site_index,
    input logic                       last
);
    import vlr_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(site_index)
            && $stable(last) && $stable(voxel_x))
        else $error("stalled result changed");

    // Outside points carry a zero index
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_grid |-> site_index == '0)
        else $error("outside point with nonzero index");

    // A line holds the input side off once it is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after accepting a line");

    // No result is valid when reset is released
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid at reset release");

endmodule

bind voxel_line_rasterizer_3d vlr_checker #(
    .COORD_BITS (COORD_BITS)
) u_vlr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .voxel_x     (voxel_x),
    .inside_grid (inside_grid),
    .site_index  (site_index),
    .last        (last)
);
